[sv/pfle_pkg.sv]
package pfle_pkg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] page;
        logic [2:0]  new_location;
        logic [2:0]  list_select;
        logic [12:0] ceiling;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] page_out;
        logic [12:0] list_total;
        logic [12:0] free_total;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_TRANS = 2'd0,
        CMD_HEAD  = 2'd1,
        CMD_BELOW = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ILLEGAL = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EV,
        S_APP,
        S_CLR,
        S_FIN
    } t_state;

    localparam logic [2:0] LOC_ZEROED   = 3'd0;
    localparam logic [2:0] LOC_FREE     = 3'd1;
    localparam logic [2:0] LOC_STANDBY  = 3'd2;
    localparam logic [2:0] LOC_MODIFIED = 3'd3;
    localparam logic [2:0] LOC_MOD_NW   = 3'd4;
    localparam logic [2:0] LOC_BAD      = 3'd5;
    localparam logic [2:0] LOC_ACTIVE   = 3'd6;

    localparam logic [2:0] LIST_ZEROED   = 3'd0;
    localparam logic [2:0] LIST_FREE     = 3'd1;
    localparam logic [2:0] LIST_STANDBY  = 3'd2;
    localparam logic [2:0] LIST_MODIFIED = 3'd3;
    localparam logic [2:0] LIST_BAD      = 3'd4;
    localparam logic [2:0] NO_LIST       = 3'd5;
    localparam int         NUM_LISTS     = 5;

    function automatic logic [2:0] list_of(input logic [2:0] loc);
        case (loc)
            LOC_ZEROED:   list_of = LIST_ZEROED;
            LOC_FREE:     list_of = LIST_FREE;
            LOC_STANDBY:  list_of = LIST_STANDBY;
            LOC_MODIFIED: list_of = LIST_MODIFIED;
            LOC_MOD_NW:   list_of = LIST_MODIFIED;
            LOC_BAD:      list_of = LIST_BAD;
            default:      list_of = NO_LIST;
        endcase
    endfunction

    function automatic logic is_legal(input logic [2:0] from, input logic [2:0] to);
        if (to == LOC_BAD)
            is_legal = 1'b1;
        else if (to == LOC_ACTIVE)
            is_legal = (from == LOC_ZEROED) || (from == LOC_FREE) || (from == LOC_STANDBY);
        else if (from == LOC_ACTIVE)
            is_legal = (to == LOC_MODIFIED) || (to == LOC_STANDBY) || (to == LOC_FREE);
        else if (from == LOC_MODIFIED)
            is_legal = (to == LOC_STANDBY);
        else if (from == LOC_FREE)
            is_legal = (to == LOC_ZEROED);
        else if (from == LOC_STANDBY)
            is_legal = (to == LOC_FREE);
        else
            is_legal = 1'b0;
    endfunction

endpackage

[sv/page_frame_list_engine.sv]
// Page frame list engine.
// Input channel: i_in_valid / o_in_stall carrying one command word (t_in_word).
// Output channel: o_out_valid / i_out_stall carrying one result word per command.
// Config channel: i_cfg_valid / o_cfg_ready writes highest_page; always ready.
// Links and locations sit in three single-port-write memories with registered
// reads; list heads, tails and counts are flops.
// Steps: range errors go straight to the result. A legal transition reads the
// frame, evaluates it, appends it to its new list unless it goes active, then
// clears its links. A take reads, then evaluates, each frame of its list walk.
// One command is in flight at a time; the next is taken once the result sits
// in the output register, which holds while the receiver stalls.
// After reset the memories are swept, one entry per cycle, over all PAGES entries;
// no command is taken during the sweep. Config writes are taken throughout.
module page_frame_list_engine
    import pfle_pkg::*;
#(
    parameter int PAGES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [11:0] i_cfg_data
);

    localparam int AW = $clog2(PAGES);
    localparam int LW = $clog2(PAGES + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(PAGES);

    logic [LW-1:0] next_mem [PAGES];
    logic [LW-1:0] prev_mem [PAGES];
    logic [2:0]    loc_mem  [PAGES];

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic [11:0]   r_highest;
    t_cmd          r_cmd, n_cmd;
    logic [LW-1:0] r_ptr, n_ptr;
    logic [2:0]    r_newloc, n_newloc;
    logic [2:0]    r_sel, n_sel;
    logic [12:0]   r_ceiling, n_ceiling;
    logic [LW-1:0] r_steps, n_steps;
    t_status       r_status, n_status;
    logic [11:0]   r_taken, n_taken;
    logic [2:0]    r_tsel, n_tsel;
    logic          r_tzero, n_tzero;
    logic          r_clr_prev, n_clr_prev;
    logic [LW-1:0] r_head  [NUM_LISTS];
    logic [LW-1:0] r_tail  [NUM_LISTS];
    logic [LW-1:0] r_count [NUM_LISTS];
    logic [LW-1:0] n_head  [NUM_LISTS];
    logic [LW-1:0] n_tail  [NUM_LISTS];
    logic [LW-1:0] n_count [NUM_LISTS];
    logic          r_out_valid;
    t_out_word     r_out_word;

    logic [LW-1:0] r_rd_next, r_rd_prev;
    logic [2:0]    r_rd_loc;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          nx_we, pv_we, lc_we;
    logic [AW-1:0] nx_addr, pv_addr, lc_addr;
    logic [LW-1:0] nx_data, pv_data;
    logic [2:0]    lc_data;

    logic          accept;
    logic          out_free;
    logic          ptr_frame, fl_frame, bl_frame, found, legal_ok;
    logic [2:0]    ol, nl, ul;
    logic          do_unlink;
    logic [LW-1:0] app_tail;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign ptr_frame = (32'(r_ptr) < PAGES) && (32'(r_steps) < PAGES);
    assign fl_frame  = 32'(r_rd_next) < PAGES;
    assign bl_frame  = 32'(r_rd_prev) < PAGES;
    assign found     = (r_cmd == CMD_HEAD) || (32'(r_ptr) < 32'(r_ceiling));
    assign legal_ok  = is_legal(r_rd_loc, r_newloc);
    assign ol        = list_of(r_rd_loc);
    assign nl        = list_of(r_newloc);
    assign app_tail  = r_tail[nl];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_in_word.cmd))
                        CMD_TRANS: begin
                            if (i_in_word.page > r_highest || 32'(i_in_word.page) >= PAGES)
                                n_state = S_FIN;
                            else
                                n_state = S_RD;
                        end
                        CMD_HEAD, CMD_BELOW: begin
                            if (i_in_word.list_select > LIST_BAD) n_state = S_FIN;
                            else n_state = S_RD;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_RD: begin
                if (r_cmd == CMD_TRANS || ptr_frame) n_state = S_EV;
                else n_state = S_FIN;
            end
            S_EV: begin
                if (r_cmd == CMD_TRANS) begin
                    if (!legal_ok) n_state = S_FIN;
                    else if (nl != NO_LIST) n_state = S_APP;
                    else n_state = S_CLR;
                end else begin
                    n_state = found ? S_CLR : S_RD;
                end
            end
            S_APP:   n_state = S_CLR;
            S_CLR:   n_state = S_FIN;
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd      = r_cmd;
        n_ptr      = r_ptr;
        n_newloc   = r_newloc;
        n_sel      = r_sel;
        n_ceiling  = r_ceiling;
        n_steps    = r_steps;
        n_status   = r_status;
        n_taken    = r_taken;
        n_tsel     = r_tsel;
        n_tzero    = r_tzero;
        n_clr_prev = r_clr_prev;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        rd_en   = 1'b0;
        rd_addr = r_ptr[AW-1:0];
        nx_we = 1'b0; nx_addr = r_ptr[AW-1:0]; nx_data = NULL_LINK;
        pv_we = 1'b0; pv_addr = r_ptr[AW-1:0]; pv_data = NULL_LINK;
        lc_we = 1'b0; lc_addr = r_ptr[AW-1:0]; lc_data = LOC_ACTIVE;
        do_unlink = 1'b0;
        ul = r_sel;
        case (r_state)
            S_CLEAR: begin
                nx_we = 1'b1; nx_addr = r_clr_addr;
                pv_we = 1'b1; pv_addr = r_clr_addr;
                lc_we = 1'b1; lc_addr = r_clr_addr;
            end
            S_IDLE: begin
                if (accept) begin
                    n_cmd     = t_cmd'(i_in_word.cmd);
                    n_newloc  = i_in_word.new_location;
                    n_sel     = i_in_word.list_select;
                    n_ceiling = i_in_word.ceiling;
                    n_steps   = '0;
                    n_status  = ST_OK;
                    n_taken   = '0;
                    n_tsel    = i_in_word.list_select;
                    n_tzero   = 1'b0;
                    case (t_cmd'(i_in_word.cmd))
                        CMD_TRANS: begin
                            n_ptr = LW'(i_in_word.page);
                            if (i_in_word.page > r_highest
                                || 32'(i_in_word.page) >= PAGES) begin
                                n_status = ST_RANGE;
                                n_tzero  = 1'b1;
                            end
                        end
                        CMD_HEAD, CMD_BELOW: begin
                            if (i_in_word.list_select > LIST_BAD) begin
                                n_status = ST_RANGE;
                                n_tzero  = 1'b1;
                            end else begin
                                n_ptr = r_head[i_in_word.list_select];
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                            n_tzero  = 1'b1;
                        end
                    endcase
                end
            end
            S_RD: begin
                if (r_cmd == CMD_TRANS || ptr_frame) rd_en = 1'b1;
                else n_status = ST_EMPTY;
            end
            S_EV: begin
                if (r_cmd == CMD_TRANS) begin
                    if (!legal_ok) begin
                        n_status = ST_ILLEGAL;
                        n_tzero  = 1'b1;
                    end else begin
                        do_unlink  = (ol != NO_LIST);
                        ul         = ol;
                        lc_we      = 1'b1;
                        lc_data    = r_newloc;
                        n_tsel     = (nl != NO_LIST) ? nl : ol;
                        n_clr_prev = (nl == NO_LIST);
                    end
                end else if (found) begin
                    do_unlink  = 1'b1;
                    ul         = r_sel;
                    lc_we      = 1'b1;
                    lc_data    = LOC_ACTIVE;
                    n_taken    = 12'(r_ptr);
                    n_clr_prev = 1'b1;
                end else begin
                    n_ptr   = r_rd_next;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_APP: begin
                pv_we   = 1'b1;
                pv_data = app_tail;
                if (32'(app_tail) < PAGES) begin
                    nx_we   = 1'b1;
                    nx_addr = app_tail[AW-1:0];
                    nx_data = r_ptr;
                end else begin
                    n_head[nl] = r_ptr;
                end
                n_tail[nl]  = r_ptr;
                n_count[nl] = r_count[nl] + 1'b1;
            end
            S_CLR: begin
                nx_we = 1'b1;
                pv_we = r_clr_prev;
            end
            default: ;
        endcase
        if (do_unlink) begin
            if (bl_frame) begin
                nx_we   = 1'b1;
                nx_addr = r_rd_prev[AW-1:0];
                nx_data = r_rd_next;
            end else begin
                n_head[ul] = r_rd_next;
            end
            if (fl_frame) begin
                pv_we   = 1'b1;
                pv_addr = r_rd_next[AW-1:0];
                pv_data = r_rd_prev;
            end else begin
                n_tail[ul] = r_rd_prev;
            end
            if (r_count[ul] != '0) n_count[ul] = r_count[ul] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_next <= next_mem[rd_addr];
            r_rd_prev <= prev_mem[rd_addr];
            r_rd_loc  <= loc_mem[rd_addr];
        end
        if (nx_we) next_mem[nx_addr] <= nx_data;
        if (pv_we) prev_mem[pv_addr] <= pv_data;
        if (lc_we) loc_mem[lc_addr]  <= lc_data;
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ptr      <= n_ptr;
        r_newloc   <= n_newloc;
        r_sel      <= n_sel;
        r_ceiling  <= n_ceiling;
        r_steps    <= n_steps;
        r_status   <= n_status;
        r_taken    <= n_taken;
        r_tsel     <= n_tsel;
        r_tzero    <= n_tzero;
        r_clr_prev <= n_clr_prev;
        if (r_state == S_FIN && out_free) begin
            r_out_word.status     <= r_status;
            r_out_word.page_out   <= r_taken;
            r_out_word.list_total <= r_tzero ? 13'd0 : 13'(r_count[r_tsel]);
            r_out_word.free_total <= 13'(r_count[LIST_ZEROED] + r_count[LIST_FREE]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_highest   <= 12'd4095;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i]  <= NULL_LINK;
                r_tail[i]  <= NULL_LINK;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cfg_valid) r_highest <= i_cfg_data;
            if (r_state == S_FIN && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> o_in_stall)
        else $error("command taken during sweep");

    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |-> o_out_word.page_out == 12'd0)
        else $error("page reported on failed command");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count[LIST_ZEROED]) + 32'(r_count[LIST_FREE]) <= PAGES)
        else $error("free count exceeds table size");

endmodule
